>>> sv/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants for the stream substring finder
// Word layouts of both channels, configuration register indexes, ASCII
// folding constants and the case-folding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

  // Default maximum needle length in bytes
  localparam int unsigned MAX_NEEDLE_DEF = 16;

  // Configuration register index width and data width
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Needle length register width (values 0 to 31)
  localparam int unsigned LEN_W = 5;

  // ASCII folding constants
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_DELTA = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LOW    = 3'd0,
    REG_NEEDLE_HIGH   = 3'd1,
    REG_NEEDLE_LENGTH = 3'd2,
    REG_MATCH_CASE    = 3'd3,
    REG_START_OFFSET  = 3'd4
  } cfg_reg_e;

  // Input word: one haystack byte plus end-of-range marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic        found;
    logic [63:0] match_offset;
  } out_word_t;

  // Fold ASCII A-Z to lower case unless exact matching is selected
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
    logic [7:0] res;
    res = b;
    if (!exact && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
      res = b + ASCII_CASE_DELTA;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/stream_substring_finder_unit.sv
// ----------------------------------------------------------------------------
// stream_substring_finder_unit: first-match search of a needle in a byte stream
// Compares each incoming byte, together with the window of preceding bytes,
// against a configured needle of up to MAX_NEEDLE bytes, with optional ASCII
// case folding, and reports the absolute offset of the first match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) carries one haystack
//   byte per word; the word with last set closes the search range. Output
//   channel (out_valid_o / out_ready_i / out_word_o) carries at most one word
//   per range: found=1 with the match start offset at the first match, or
//   found=0 (offset 0) on the last byte when nothing matched.
//   Throughput: one input word per cycle while the output is not stalled.
//   A result is in the output register the cycle after its byte is accepted.
//   The window compare for all needle lengths runs in parallel in the cycle
//   a byte is accepted; the output register is the only pipeline stage.
//   Bytes after a match are consumed without results until the last byte,
//   which clears window, byte count and match flag.
//   Receiver stall: a pending result sits in the output register; the input
//   stays ready as long as the register is empty or being drained.
//   Reset: registers take their reset values (needle empty, exact matching,
//   start offset 0), window and counters clear, output goes invalid.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) apply at once.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_substring_finder_unit
  import ssf_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE = MAX_NEEDLE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_word_i,
  // result stream
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_word_o
);

  localparam int unsigned WinDepth = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int unsigned CntW     = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned CmpW     = LEN_W + 1;

  // configuration registers
  logic [127:0]      needle_q;
  logic [LEN_W-1:0]  len_q;
  logic              exact_q;
  logic [63:0]       start_q;

  // range state
  logic [7:0]        win_q [WinDepth];
  logic [63:0]       seen_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;

  // output register
  logic              out_valid_q;
  out_word_t         out_q;

  // datapath
  logic              in_acc;
  logic [7:0]        cur_f;
  logic [7:0]        win_f [WinDepth];
  logic [7:0]        ndl_f [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] match_len;
  logic              len_ok;
  logic              enough;
  logic              hit;
  logic [63:0]       offset;

  // ---------------------------------------------------------------------------
  // Handshake
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      len_q    <= '0;
      exact_q  <= 1'b1;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NEEDLE_LOW:    needle_q[63:0]   <= cfg_data_i;
        REG_NEEDLE_HIGH:   needle_q[127:64] <= cfg_data_i;
        REG_NEEDLE_LENGTH: len_q            <= cfg_data_i[LEN_W-1:0];
        REG_MATCH_CASE:    exact_q          <= cfg_data_i[0];
        REG_START_OFFSET:  start_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Case folding of incoming byte, window and needle
  always_comb begin
    cur_f = fold_byte(in_word_i.data_byte, exact_q);
    for (int k = 0; k < WinDepth; k++) begin
      win_f[k] = fold_byte(win_q[k], exact_q);
    end
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      ndl_f[i] = fold_byte(needle_q[8*i +: 8], exact_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Parallel compare: one match flag per possible needle length.
  // Needle byte l-1 lines up with the new byte, byte i with window l-2-i.
  always_comb begin
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      match_len[l-1] = (cur_f == ndl_f[l-1]);
      for (int i = 0; i < l - 1; i++) begin
        if (win_f[l-2-i] != ndl_f[i]) begin
          match_len[l-1] = 1'b0;
        end
      end
    end
  end

  // Select by configured length, require enough bytes of this range
  always_comb begin
    len_ok = (len_q != '0) && (CmpW'(len_q) <= CmpW'(MAX_NEEDLE));
    enough = (CmpW'(cnt_q) >= (CmpW'(len_q) - CmpW'(1)));
    hit    = 1'b0;
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      if (match_len[l-1] && (len_q == LEN_W'(l))) begin
        hit = 1'b1;
      end
    end
    hit    = hit && len_ok && enough;
    offset = start_q + seen_q + 64'd1 - 64'(len_q);
  end

  // ---------------------------------------------------------------------------
  // Range state: window shift, byte counters, match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinDepth; k++) begin
        win_q[k] <= '0;
      end
      seen_q <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (in_acc) begin
      if (in_word_i.last) begin
        for (int k = 0; k < WinDepth; k++) begin
          win_q[k] <= '0;
        end
        seen_q <= '0;
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (!done_q) begin
        win_q[0] <= in_word_i.data_byte;
        for (int k = 1; k < WinDepth; k++) begin
          win_q[k] <= win_q[k-1];
        end
        seen_q <= seen_q + 64'd1;
        if (cnt_q != CntW'(MAX_NEEDLE)) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        done_q <= hit;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && !done_q && (hit || in_word_i.last)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !done_q && (hit || in_word_i.last)) begin
      out_q.found        <= hit;
      out_q.match_offset <= hit ? offset : 64'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.last) |=> (seen_q == 64'd0 && cnt_q == '0 && !done_q))
    else $error("range state not cleared after last word");

  a_hit_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !done_q && hit && !in_word_i.last) |=> done_q)
    else $error("match flag not set after a match");

  a_miss_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.found) |-> (out_word_o.match_offset == 64'd0))
    else $error("not-found result carries a nonzero offset");

  a_quiet_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && done_q && out_ready_i) |=> !out_valid_q)
    else $error("result produced after the range already matched");

endmodule

`default_nettype wire
